// ----- hw/rtl/ttl_key_value_store_macros.svh -----
// Assertion macros for the key value store
`ifndef TTL_KEY_VALUE_STORE_MACROS_SVH
`define TTL_KEY_VALUE_STORE_MACROS_SVH

// Assert that an antecedent implies a consequent on the same edge
`define TTL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Assert that an antecedent implies a consequent on the following edge
`define TTL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/ttl_pkg.sv -----
`default_nettype none
package ttl_pkg;

  localparam int unsigned KEY_W    = 32;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned SUM_W    = 38;
  localparam int unsigned AVG_W    = 40;

  // Opcodes
  localparam logic [1:0] OP_SET = 2'd0;
  localparam logic [1:0] OP_GET = 2'd1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_SET_NEW  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_SET_REPL = 3'd1;
  localparam logic [STATUS_W-1:0] ST_GET_HIT  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_GET_MISS = 3'd3;
  localparam logic [STATUS_W-1:0] ST_OBSERVED = 3'd4;
  localparam logic [STATUS_W-1:0] ST_SET_DROP = 3'd5;

  // Divider request to the average unit
  typedef struct packed {
    logic             go;
    logic             neg;
    logic [SUM_W-1:0] mag;
    logic [COUNT_W-1:0] cnt;
  } div_req_t;

endpackage
`default_nettype wire

// ----- hw/rtl/ttl_avg_div.sv -----
`default_nettype none
module ttl_avg_div #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire ttl_pkg::div_req_t req,
  output logic                 done,
  output logic [ttl_pkg::AVG_W-1:0] quot
);
  import ttl_pkg::*;

  localparam int unsigned NUM_W = SUM_W + FRAC_BITS;
  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0]   num_r, num_nxt;
  logic [COUNT_W:0]   rem_r, rem_nxt;
  logic [COUNT_W-1:0] dvs_r;
  logic               neg_r;
  logic [CNT_W-1:0]   step_r, step_nxt;
  logic               busy_r;
  logic [COUNT_W:0]   trial;
  logic [NUM_W-1:0]   negq;

  // One quotient bit per cycle by restoring division
  always_comb begin
    trial    = {rem_r[COUNT_W-1:0], num_r[NUM_W-1]};
    rem_nxt  = trial;
    num_nxt  = {num_r[NUM_W-2:0], 1'b0};
    if (trial >= {1'b0, dvs_r}) begin
      rem_nxt    = trial - {1'b0, dvs_r};
      num_nxt[0] = 1'b1;
    end
    step_nxt = step_r - 1'b1;
    negq     = '0 - num_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
      step_r <= '0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        busy_r <= 1'b1;
        step_r <= CNT_W'(NUM_W);
        num_r  <= {req.mag, {FRAC_BITS{1'b0}}};
        rem_r  <= '0;
        dvs_r  <= req.cnt;
        neg_r  <= req.neg;
      end else if (busy_r) begin
        num_r  <= num_nxt;
        rem_r  <= rem_nxt;
        step_r <= step_nxt;
        if (step_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  // Apply the sign to the magnitude quotient; a zero divisor gives zero
  always_comb begin
    if (dvs_r == '0) quot = '0;
    else if (neg_r) quot = AVG_W'(negq);
    else quot = AVG_W'(num_r);
  end
endmodule
`default_nettype wire

// ----- hw/rtl/ttl_key_value_store.sv -----
`default_nettype none
`include "ttl_key_value_store_macros.svh"
// Key value store with expiry. One transaction at a time: start is taken while
// busy is low; the result appears on out_* with out_valid high for one cycle and
// cannot be held off. Each transaction runs an expiry pass, a key and free-slot
// scan, a write state, the bit-serial divider for the average and an output
// state. The next start is taken in the cycle that out_valid is high.
// The entry memory has one write port and one read port whose read data is
// registered, which sets the scan length. After reset no clearing pass is needed.
module ttl_key_value_store #(
  parameter int unsigned CAPACITY  = 64,
  parameter int unsigned FRAC_BITS = 8
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic      busy,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [31:0] in_key,
  input  wire logic signed [31:0] in_value,
  input  wire logic [31:0] in_current_time,
  input  wire logic [31:0] in_duration,
  output logic             out_valid,
  output logic [2:0]       out_status,
  output logic signed [31:0] out_value_out,
  output logic [6:0]       out_live_count,
  output logic signed [37:0] out_total_sum,
  output logic signed [39:0] out_average
);
  import ttl_pkg::*;

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned ENT_W = KEY_W + VAL_W + TIME_W;

  typedef enum logic [2:0] {
    S_IDLE, S_EXP, S_SCAN, S_WRITE, S_DIV, S_OUT
  } state_t;

  state_t state_r;

  // Entry memory: key, value, expiry; valid bits in flip-flops
  logic [ENT_W-1:0] mem [CAPACITY];
  logic [ENT_W-1:0] rd_r;
  logic [CAPACITY-1:0] valid_r;

  logic [IDX_W:0]   addr_r;     // issue counter
  logic [IDX_W:0]   chk_r;      // index of data in rd_r
  logic             rd_ok_r;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [ENT_W-1:0] wr_data;

  logic [1:0]  op_r;
  logic [31:0] key_r;
  logic signed [31:0] val_r;
  logic [31:0] now_r;
  logic [31:0] exp_r;

  logic [COUNT_W-1:0] live_r;
  logic signed [SUM_W-1:0] sum_r;

  logic             hit_r, free_ok_r;
  logic [IDX_W-1:0] hit_idx_r, free_idx_r;
  logic signed [VAL_W-1:0] hit_val_r;
  logic [STATUS_W-1:0] status_r;
  logic signed [VAL_W-1:0] vout_r;

  logic [KEY_W-1:0]  rd_key;
  logic [VAL_W-1:0]  rd_val;
  logic [TIME_W-1:0] rd_exp;
  logic [IDX_W-1:0]  chk_idx;
  logic [32:0]       exp_sum;

  div_req_t dreq;
  logic     ddone;
  logic [AVG_W-1:0] dquot;

  logic signed [SUM_W-1:0] sum_after;

  assign {rd_key, rd_val, rd_exp} = rd_r;
  assign chk_idx = chk_r[IDX_W-1:0];
  assign exp_sum = {1'b0, in_current_time} + {1'b0, in_duration};
  assign busy    = (state_r != S_IDLE);

  // Memory read and write
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_r <= mem[addr_r[IDX_W-1:0]];
  end

  assign wr_en   = (state_r == S_WRITE) && (hit_r || free_ok_r) && (op_r == OP_SET);
  assign wr_addr = hit_r ? hit_idx_r : free_idx_r;
  assign wr_data = {key_r, val_r, exp_r};

  // Sum after the write, used for the divider operand
  always_comb begin
    sum_after = sum_r;
    if (wr_en) begin
      sum_after = sum_r + SUM_W'(val_r);
      if (hit_r) sum_after = sum_after - SUM_W'(hit_val_r);
    end
  end

  // Divider request on leaving the write state
  always_comb begin
    dreq.go  = (state_r == S_WRITE);
    dreq.neg = sum_after[SUM_W-1];
    dreq.mag = sum_after[SUM_W-1] ? SUM_W'(-sum_after) : SUM_W'(sum_after);
    dreq.cnt = live_r;
    if (wr_en && !hit_r) dreq.cnt = live_r + 1'b1;
  end

  ttl_avg_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (dreq),
    .done (ddone),
    .quot (dquot)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      valid_r   <= '0;
      live_r    <= '0;
      sum_r     <= '0;
      out_valid <= 1'b0;
      rd_ok_r   <= 1'b0;
      addr_r    <= '0;
      chk_r     <= '0;
    end else begin
      out_valid <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            op_r    <= in_opcode;
            key_r   <= in_key;
            val_r   <= in_value;
            now_r   <= in_current_time;
            exp_r   <= exp_sum[32] ? 32'hFFFF_FFFF : exp_sum[31:0];
            addr_r  <= '0;
            rd_ok_r <= 1'b0;
            state_r <= S_EXP;
          end
        end
        // Expire pass: drop entries whose expiry is at or before the current time
        S_EXP: begin
          addr_r  <= addr_r + 1'b1;
          chk_r   <= addr_r;
          rd_ok_r <= (addr_r < (IDX_W+1)'(CAPACITY));
          if (rd_ok_r && valid_r[chk_idx] && rd_exp <= now_r) begin
            valid_r[chk_idx] <= 1'b0;
            sum_r  <= sum_r - SUM_W'(signed'(rd_val));
            live_r <= live_r - 1'b1;
          end
          if (rd_ok_r && chk_r == (IDX_W+1)'(CAPACITY-1)) begin
            addr_r    <= '0;
            rd_ok_r   <= 1'b0;
            hit_r     <= 1'b0;
            free_ok_r <= 1'b0;
            state_r   <= S_SCAN;
          end
        end
        // Key and free-slot scan
        S_SCAN: begin
          addr_r  <= addr_r + 1'b1;
          chk_r   <= addr_r;
          rd_ok_r <= (addr_r < (IDX_W+1)'(CAPACITY));
          if (rd_ok_r) begin
            if (valid_r[chk_idx] && rd_key == key_r && !hit_r) begin
              hit_r     <= 1'b1;
              hit_idx_r <= chk_idx;
              hit_val_r <= rd_val;
            end
            if (!valid_r[chk_idx] && !free_ok_r) begin
              free_ok_r  <= 1'b1;
              free_idx_r <= chk_idx;
            end
            if (chk_r == (IDX_W+1)'(CAPACITY-1)) state_r <= S_WRITE;
          end
        end
        S_WRITE: begin
          vout_r   <= '0;
          status_r <= ST_OBSERVED;
          if (op_r == OP_SET) begin
            if (hit_r) status_r <= ST_SET_REPL;
            else if (free_ok_r) status_r <= ST_SET_NEW;
            else status_r <= ST_SET_DROP;
            if (wr_en) begin
              valid_r[wr_addr] <= 1'b1;
              sum_r <= sum_after;
              if (!hit_r) live_r <= live_r + 1'b1;
            end
          end else if (op_r == OP_GET) begin
            status_r <= hit_r ? ST_GET_HIT : ST_GET_MISS;
            if (hit_r) vout_r <= hit_val_r;
          end
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (ddone) state_r <= S_OUT;
        end
        S_OUT: begin
          out_valid      <= 1'b1;
          out_status     <= status_r;
          out_value_out  <= vout_r;
          out_live_count <= live_r;
          out_total_sum  <= sum_r;
          out_average    <= dquot;
          state_r        <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Checks
  `TTL_ASSERT_IMP(a_out_idle, clk, rst_n, out_valid, state_r == S_IDLE, "result outside idle")
  `TTL_ASSERT_IMP(a_live_bound, clk, rst_n, 1'b1, live_r <= COUNT_W'(CAPACITY), "live count overflow")
  `TTL_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy, "start not taken")
endmodule
`default_nettype wire
